>>> design/cdu_pkg.sv
// ----------------------------------------------------------------------------
// cdu_pkg: shared types and constants of the character-cell update block
// Geometry, field widths, command and register codes, and the cell address.
// ----------------------------------------------------------------------------
package cdu_pkg;

    // Geometry of the cell buffers.
    localparam int COLS   = 32;
    localparam int ROWS   = 32;
    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    // Field widths fixed by the item format.
    localparam int COL_W   = 5;
    localparam int ROW_W   = 5;
    localparam int COLOR_W = 16;
    localparam int CHAR_W  = 8;
    localparam int SIZE_W  = 6;
    localparam int CFG_IDX_W = 2;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character code of an empty cell.
    localparam logic [CHAR_W-1:0] EMPTY_CHAR = 8'd255;

    // Sizes in force after reset.
    localparam logic [SIZE_W-1:0] RESET_COLS = 6'd30;
    localparam logic [SIZE_W-1:0] RESET_ROWS = 6'd30;

    // Last physical column of a row.
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

    typedef enum logic
    {
        OP_PLOT  = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_ACTIVE_COLS = 2'd0,
        REG_ACTIVE_ROWS = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINAL
    } back_state_t;

    // One stored cell: color in the upper bits, character in the lower.
    typedef struct packed
    {
        logic [COLOR_W-1:0] color;
        logic [CHAR_W-1:0]  character;
    } cell_t;

    // A classified command passed from the front to the back.
    typedef struct packed
    {
        logic               flush;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        cell_t              content;
    } cmd_t;

    // Linear buffer address of a cell.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(COLS);
        return base + ADDR_W'(col);
    endfunction

endpackage

>>> design/cdu_if.sv
// ----------------------------------------------------------------------------
// cdu_if: channel interfaces of the character-cell update block
// Request channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface cdu_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [cdu_pkg::COL_W-1:0]    col;
    logic [cdu_pkg::ROW_W-1:0]    row;
    logic [cdu_pkg::COLOR_W-1:0]  color;
    logic [cdu_pkg::CHAR_W-1:0]   character;

    modport source (output valid, op, col, row, color, character, input ready);
    modport sink   (input valid, op, col, row, color, character, output ready);
endinterface

interface cdu_out_if;
    logic                         valid;
    logic                         ready;
    logic [cdu_pkg::COL_W-1:0]    out_col;
    logic [cdu_pkg::ROW_W-1:0]    out_row;
    logic [cdu_pkg::COLOR_W-1:0]  out_color;
    logic [cdu_pkg::CHAR_W-1:0]   out_char;
    logic                         erase;
    logic                         last;

    modport source (output valid, out_col, out_row, out_color, out_char, erase, last,
                    input ready);
    modport sink   (input valid, out_col, out_row, out_color, out_char, erase, last,
                    output ready);
endinterface

interface cdu_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cdu_pkg::CFG_IDX_W-1:0]  idx;
    logic [cdu_pkg::SIZE_W-1:0]     data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

>>> design/cdu_front.sv
// ----------------------------------------------------------------------------
// cdu_front: request intake and classification
// Holds the active size registers, drops plots outside the active area and
// passes the remaining requests to the command queue.
// ----------------------------------------------------------------------------
module cdu_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    cdu_in_if.sink                items,
    cdu_cfg_if.sink               cfg,
    input  logic                  clearing,
    input  logic                  q_full,
    output logic                  push,
    output cdu_pkg::cmd_t         push_cmd
);

    logic [cdu_pkg::SIZE_W-1:0] active_cols_reg;
    logic [cdu_pkg::SIZE_W-1:0] active_rows_reg;
    logic [cdu_pkg::SIZE_W-1:0] active_cols_next;
    logic [cdu_pkg::SIZE_W-1:0] active_rows_next;
    logic                       accept;
    logic                       keep;
    logic                       in_area;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        active_cols_next = active_cols_reg;
        active_rows_next = active_rows_reg;
        if (cfg.valid)
        begin
            unique case (cfg.idx)
                cdu_pkg::REG_ACTIVE_COLS: active_cols_next = cfg.data;
                cdu_pkg::REG_ACTIVE_ROWS: active_rows_next = cfg.data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_cols_reg <= cdu_pkg::RESET_COLS;
            active_rows_reg <= cdu_pkg::RESET_ROWS;
        end
        else
        begin
            active_cols_reg <= active_cols_next;
            active_rows_reg <= active_rows_next;
        end
    end

    // A plot lands only inside both the active and the physical area.
    always_comb
    begin
        in_area = ({1'b0, items.col} < active_cols_reg) &&
                  ({1'b0, items.row} < active_rows_reg) &&
                  (int'(items.col) < cdu_pkg::COLS) &&
                  (int'(items.row) < cdu_pkg::ROWS);
        if (items.op == cdu_pkg::OP_PLOT)
            keep = in_area;
        else
            keep = int'(items.row) < cdu_pkg::ROWS;
    end

    assign items.ready = !clearing && !q_full;
    assign accept      = items.valid && items.ready;
    assign push        = accept && keep;

    assign push_cmd.flush             = (items.op == cdu_pkg::OP_FLUSH);
    assign push_cmd.col               = items.col;
    assign push_cmd.row               = items.row;
    assign push_cmd.content.color     = items.color;
    assign push_cmd.content.character = items.character;

endmodule

>>> design/cdu_queue.sv
// ----------------------------------------------------------------------------
// cdu_queue: short command queue between the front and the back
// A small circular buffer that lets either side stall on its own.
// ----------------------------------------------------------------------------
module cdu_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cdu_pkg::cmd_t         push_cmd,
    output logic                  full,
    input  logic                  pop,
    output logic                  q_valid,
    output cdu_pkg::cmd_t         q_cmd
);

    localparam logic [cdu_pkg::QPTR_W-1:0] PTR_LAST = cdu_pkg::QPTR_W'(cdu_pkg::QUEUE_DEPTH - 1);
    localparam logic [cdu_pkg::QCNT_W-1:0] CNT_FULL = cdu_pkg::QCNT_W'(cdu_pkg::QUEUE_DEPTH);

    cdu_pkg::cmd_t                 slot_reg [cdu_pkg::QUEUE_DEPTH];
    logic [cdu_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [cdu_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [cdu_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [cdu_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [cdu_pkg::QCNT_W-1:0]    count_reg;
    logic [cdu_pkg::QCNT_W-1:0]    count_next;

    assign full    = (count_reg == CNT_FULL);
    assign q_valid = (count_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> design/cdu_back.sv
// ----------------------------------------------------------------------------
// cdu_back: buffer keeper and row scanner
// Owns the pending and shown buffers, clears them after reset, performs
// plots and walks a row on a flush, emitting each changed cell.
// ----------------------------------------------------------------------------
module cdu_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  cdu_pkg::cmd_t         q_cmd,
    output logic                  pop,
    output logic                  clearing,
    cdu_out_if.source             results
);

    localparam logic [cdu_pkg::ADDR_W-1:0] ADDR_LAST = cdu_pkg::ADDR_W'(cdu_pkg::CELLS - 1);

    // Buffers.
    cdu_pkg::cell_t pending_mem [cdu_pkg::CELLS];
    cdu_pkg::cell_t shown_mem   [cdu_pkg::CELLS];

    cdu_pkg::cell_t                p_rdata_reg;
    cdu_pkg::cell_t                s_rdata_reg;
    logic                          p_we;
    logic [cdu_pkg::ADDR_W-1:0]    p_waddr;
    cdu_pkg::cell_t                p_wdata;
    logic                          s_we;
    logic [cdu_pkg::ADDR_W-1:0]    s_waddr;
    cdu_pkg::cell_t                s_wdata;
    logic                          rd_en;
    logic [cdu_pkg::ADDR_W-1:0]    rd_addr;

    // Control.
    cdu_pkg::back_state_t          state_reg, state_next;
    logic [cdu_pkg::ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [cdu_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [cdu_pkg::COL_W-1:0]     issue_col_reg, issue_col_next;
    logic                          issue_done_reg, issue_done_next;
    logic                          cmp_valid_reg, cmp_valid_next;
    logic [cdu_pkg::COL_W-1:0]     cmp_col_reg, cmp_col_next;
    logic                          held_valid_reg, held_valid_next;
    logic [cdu_pkg::COL_W-1:0]     held_col_reg, held_col_next;
    cdu_pkg::cell_t                held_cell_reg, held_cell_next;
    logic                          out_valid_reg, out_valid_next;
    logic [cdu_pkg::COL_W-1:0]     out_col_reg, out_col_next;
    logic [cdu_pkg::ROW_W-1:0]     out_row_reg, out_row_next;
    cdu_pkg::cell_t                out_cell_reg, out_cell_next;
    logic                          out_last_reg, out_last_next;

    logic                          out_free;
    logic                          changed;
    logic                          stall;

    assign clearing = (state_reg == cdu_pkg::ST_CLEAR);
    assign out_free = !out_valid_reg || results.ready;
    assign changed  = (p_rdata_reg != s_rdata_reg);
    // A second changed cell can only move on once the held one leaves.
    assign stall    = cmp_valid_reg && changed && held_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        row_next        = row_reg;
        issue_col_next  = issue_col_reg;
        issue_done_next = issue_done_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_col_next    = cmp_col_reg;
        held_valid_next = held_valid_reg;
        held_col_next   = held_col_reg;
        held_cell_next  = held_cell_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        out_cell_next   = out_cell_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;
        p_we            = 1'b0;
        p_waddr         = cdu_pkg::cell_addr(row_reg, cmp_col_reg);
        p_wdata         = '{color: p_rdata_reg.color, character: cdu_pkg::EMPTY_CHAR};
        s_we            = 1'b0;
        s_waddr         = cdu_pkg::cell_addr(row_reg, cmp_col_reg);
        s_wdata         = p_rdata_reg;
        rd_en           = 1'b0;
        rd_addr         = cdu_pkg::cell_addr(row_reg, issue_col_reg);

        unique case (state_reg)
            cdu_pkg::ST_CLEAR:
            begin
                p_we          = 1'b1;
                s_we          = 1'b1;
                p_waddr       = clr_addr_reg;
                s_waddr       = clr_addr_reg;
                p_wdata       = '0;
                s_wdata       = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_LAST)
                    state_next = cdu_pkg::ST_IDLE;
            end

            cdu_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    if (q_cmd.flush)
                    begin
                        row_next        = q_cmd.row;
                        issue_col_next  = '0;
                        issue_done_next = 1'b0;
                        cmp_valid_next  = 1'b0;
                        state_next      = cdu_pkg::ST_SCAN;
                    end
                    else
                    begin
                        p_we    = 1'b1;
                        p_waddr = cdu_pkg::cell_addr(q_cmd.row, q_cmd.col);
                        p_wdata = q_cmd.content;
                    end
                end
            end

            cdu_pkg::ST_SCAN:
            begin
                if (!stall)
                begin
                    if (cmp_valid_reg)
                    begin
                        p_we = 1'b1;
                        if (changed)
                        begin
                            s_we = 1'b1;
                            if (held_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_col_next   = held_col_reg;
                                out_row_next   = row_reg;
                                out_cell_next  = held_cell_reg;
                                out_last_next  = 1'b0;
                            end
                            held_valid_next = 1'b1;
                            held_col_next   = cmp_col_reg;
                            held_cell_next  = p_rdata_reg;
                        end
                        if (cmp_col_reg == cdu_pkg::COL_LAST)
                            state_next = cdu_pkg::ST_FINAL;
                    end
                    if (!issue_done_reg)
                    begin
                        rd_en          = 1'b1;
                        cmp_valid_next = 1'b1;
                        cmp_col_next   = issue_col_reg;
                        if (issue_col_reg == cdu_pkg::COL_LAST)
                            issue_done_next = 1'b1;
                        else
                            issue_col_next = issue_col_reg + 1'b1;
                    end
                    else
                    begin
                        cmp_valid_next = 1'b0;
                    end
                end
            end

            cdu_pkg::ST_FINAL:
            begin
                if (!held_valid_reg)
                begin
                    state_next = cdu_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_col_next    = held_col_reg;
                    out_row_next    = row_reg;
                    out_cell_next   = held_cell_reg;
                    out_last_next   = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = cdu_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cdu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cdu_pkg::ST_CLEAR;
            clr_addr_reg   <= '0;
            issue_done_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            issue_done_reg <= issue_done_next;
            cmp_valid_reg  <= cmp_valid_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        issue_col_reg <= issue_col_next;
        cmp_col_reg   <= cmp_col_next;
        held_col_reg  <= held_col_next;
        held_cell_reg <= held_cell_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
        out_cell_reg  <= out_cell_next;
        out_last_reg  <= out_last_next;
    end

    // Pending buffer: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (p_we)
            pending_mem[p_waddr] <= p_wdata;
        if (rd_en)
            p_rdata_reg <= pending_mem[rd_addr];
    end

    // Shown buffer: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (s_we)
            shown_mem[s_waddr] <= s_wdata;
        if (rd_en)
            s_rdata_reg <= shown_mem[rd_addr];
    end

    assign results.valid     = out_valid_reg;
    assign results.out_col   = out_col_reg;
    assign results.out_row   = out_row_reg;
    assign results.out_color = out_cell_reg.color;
    assign results.out_char  = out_cell_reg.character;
    assign results.erase     = (out_cell_reg.character == cdu_pkg::EMPTY_CHAR);
    assign results.last      = out_last_reg;

endmodule

>>> design/char_cell_dirty_update.sv
// ----------------------------------------------------------------------------
// char_cell_dirty_update: double-buffered character-cell update engine
// Plots go into a pending buffer; a flush compares one row against the
// shown buffer and reports every cell that changed.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake      Carries
//  items     in         valid/ready    op, col, row, color, character
//  results   out        valid/ready    out_col, out_row, out_color, out_char,
//                                      erase, last
//  cfg       in         valid/ready    idx (0 active_cols, 1 active_rows), data
//
// A plot is written into the pending buffer as it leaves the queue. A flush
// walks its row in the back end through the single read port of each
// buffer, which yields one cell per cycle except while the result
// register is full and not being taken.
// After reset a clearing pass writes zero into both buffers, one cell per
// cycle over all COLS * ROWS = 1024 cells, and items.ready stays low meanwhile.
// Register writes are always taken. A stalled result side stops the row
// scan in place; the command queue keeps taking requests until it fills.
//
module char_cell_dirty_update
(
    input  logic        clk,
    input  logic        rst_n,
    cdu_in_if.sink      items,
    cdu_out_if.source   results,
    cdu_cfg_if.sink     cfg
);

    // Front to queue.
    logic               push;
    cdu_pkg::cmd_t      push_cmd;
    logic               q_full;

    // Queue to back.
    logic               pop;
    logic               q_valid;
    cdu_pkg::cmd_t      q_cmd;

    // High while the buffers are being cleared after reset.
    logic               clearing;

    // The front checks each request against the active area and forwards
    // only those that can change a buffer.
    cdu_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .cfg      (cfg),
        .clearing (clearing),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // The queue decouples request intake from the row scan.
    cdu_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // The back end owns both buffers and produces the results. It holds the
    // most recent changed cell back by one so that the final one of a flush
    // can carry the last flag.
    cdu_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .clearing (clearing),
        .results  (results)
    );

    // No request is taken while the buffers are still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !(items.valid && items.ready))
        else $error("request accepted during buffer clearing");

    // The front never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("command pushed into a full queue");

    // No result can appear before clearing has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !results.valid)
        else $error("result offered during buffer clearing");

    // The back only pops a command that the queue holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("command popped from an empty queue");

endmodule

>>> test/cdu_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cdu_checker: result predictor and comparator for the character-cell updater
// Watches the request, result and register channels, keeps its own copy of
// both cell buffers and reports every result that differs from the forecast.
// ----------------------------------------------------------------------------
module cdu_checker
(
    input  logic clk,
    input  logic rst_n,
    cdu_in_if    items,
    cdu_out_if   results,
    cdu_cfg_if   cfg,
    output int   waiting,
    output int   errors
);

    localparam int FIELD_W = cdu_pkg::COLOR_W;

    typedef struct packed
    {
        logic [cdu_pkg::COL_W-1:0]   col;
        logic [cdu_pkg::ROW_W-1:0]   row;
        logic [cdu_pkg::COLOR_W-1:0] color;
        logic [cdu_pkg::CHAR_W-1:0]  character;
        logic                        erase;
        logic                        last;
    } cell_change_t;

    cdu_pkg::cell_t              pending_cells [cdu_pkg::CELLS];
    cdu_pkg::cell_t              shown_cells   [cdu_pkg::CELLS];
    logic [cdu_pkg::SIZE_W-1:0]  cols_in_use;
    logic [cdu_pkg::SIZE_W-1:0]  rows_in_use;
    cell_change_t                change_q [$];
    int                          fail_count;

    // Applies one accepted request to the buffers and queues the changes
    // that a flush of a row is bound to report.
    task automatic take_request(input cdu_pkg::op_t op,
                                input logic [cdu_pkg::COL_W-1:0] col,
                                input logic [cdu_pkg::ROW_W-1:0] row,
                                input cdu_pkg::cell_t content);
        cell_change_t found [$];
        cell_change_t chg;
        int           a;
        if (op == cdu_pkg::OP_PLOT)
        begin
            if (({1'b0, col} < cols_in_use) && ({1'b0, row} < rows_in_use))
                pending_cells[int'(row) * cdu_pkg::COLS + int'(col)] = content;
        end
        else
        begin
            for (int c = 0; c < cdu_pkg::COLS; c++)
            begin
                a = int'(row) * cdu_pkg::COLS + c;
                if (pending_cells[a] != shown_cells[a])
                begin
                    shown_cells[a]  = pending_cells[a];
                    chg.col         = cdu_pkg::COL_W'(c);
                    chg.row         = row;
                    chg.color       = pending_cells[a].color;
                    chg.character   = pending_cells[a].character;
                    chg.erase       = (pending_cells[a].character == cdu_pkg::EMPTY_CHAR);
                    chg.last        = 1'b0;
                    found.push_back(chg);
                end
                pending_cells[a].character = cdu_pkg::EMPTY_CHAR;
            end
            if (found.size() > 0)
                found[$].last = 1'b1;
            foreach (found[i])
                change_q.push_back(found[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cell_change_t want;
        if (!rst_n)
        begin
            foreach (pending_cells[i])
                pending_cells[i] = '0;
            foreach (shown_cells[i])
                shown_cells[i] = '0;
            cols_in_use = cdu_pkg::RESET_COLS;
            rows_in_use = cdu_pkg::RESET_ROWS;
            change_q.delete();
            fail_count = 0;
        end
        else
        begin
            // Results first: anything handed over now stems from earlier requests.
            if (results.valid && results.ready)
            begin
                if (change_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, got col %0d row %0d",
                             $time, results.out_col, results.out_row);
                    fail_count++;
                end
                else
                begin
                    want = change_q.pop_front();
                    check_field("out_col",   FIELD_W'(want.col),  FIELD_W'(results.out_col));
                    check_field("out_row",   FIELD_W'(want.row),  FIELD_W'(results.out_row));
                    check_field("out_color", want.color,          results.out_color);
                    check_field("out_char",  FIELD_W'(want.character),
                                FIELD_W'(results.out_char));
                    check_field("erase",     FIELD_W'(want.erase), FIELD_W'(results.erase));
                    check_field("last",      FIELD_W'(want.last),  FIELD_W'(results.last));
                end
            end
            if (items.valid && items.ready)
                take_request(cdu_pkg::op_t'(items.op), items.col, items.row,
                             cdu_pkg::cell_t'({items.color, items.character}));
            if (cfg.valid && cfg.ready)
            begin
                case (cdu_pkg::cfg_reg_t'(cfg.idx))
                    cdu_pkg::REG_ACTIVE_COLS: cols_in_use = cfg.data;
                    cdu_pkg::REG_ACTIVE_ROWS: rows_in_use = cfg.data;
                    default: ;
                endcase
            end
        end
        waiting <= change_q.size();
        errors  <= fail_count;
    end

endmodule

>>> test/tb_char_cell_dirty_update.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_cell_dirty_update: stimulus and verdict for the character-cell updater
// Drives plot and flush requests with random gaps, stalls the result side,
// steps the active area through its extremes between phases, and leaves all
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_char_cell_dirty_update;

    // Cycles allowed after the last expected result for flushes that report
    // nothing: up to two queued behind one in progress.
    localparam int SETTLE_CYCLES = 120;
    // Length of the one long stall on the result side.
    localparam int LONG_HOLD_CYCLES = 400;
    // Hard stop of the run, several times the slowest correct run.
    localparam longint LIMIT_NS = 64'd6_000_000;
    // A register index that the block does not decode; writes to it are ignored.
    localparam logic [cdu_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    cdu_in_if  items_ch ();
    cdu_out_if results_ch ();
    cdu_cfg_if cfg_ch ();

    int   waiting;
    int   errors;
    logic long_hold_req;

    // Idle-run state of each side: how many draws remain in the current
    // stretch, and whether this stretch idles at all.
    int   send_left = 0;
    bit   send_gappy = 1'b0;
    int   take_left = 0;
    bit   take_gappy = 1'b0;

    char_cell_dirty_update u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    cdu_checker u_check
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch),
        .cfg     (cfg_ch),
        .waiting (waiting),
        .errors  (errors)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Draws the number of idle cycles before the next request or result.
    // Each stretch is drawn either with random gaps or with no gaps at all,
    // so that back-to-back traffic is exercised as well.
    function automatic int draw_wait(inout int left, inout bit gappy);
        if (left == 0)
        begin
            left  = $urandom_range(8, 24);
            gappy = ($urandom_range(0, 2) != 0);
        end
        left--;
        return gappy ? $urandom_range(0, 7) : 0;
    endfunction

    // Offers one request and returns at the edge where it is accepted. The
    // valid line is only lowered when a gap follows, so that a request right
    // behind another keeps valid high without a second assignment.
    task automatic send_request(input cdu_pkg::op_t op,
                                input logic [cdu_pkg::COL_W-1:0] col,
                                input logic [cdu_pkg::ROW_W-1:0] row,
                                input logic [cdu_pkg::COLOR_W-1:0] color,
                                input logic [cdu_pkg::CHAR_W-1:0] ch);
        int gap;
        gap = draw_wait(send_left, send_gappy);
        if (gap > 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_ch.valid     <= 1'b1;
        items_ch.op        <= op;
        items_ch.col       <= col;
        items_ch.row       <= row;
        items_ch.color     <= color;
        items_ch.character <= ch;
        @(posedge clk);
        while (!items_ch.ready) @(posedge clk);
    endtask

    // Random request. Most requests land in a few rows so that flushes find
    // real changes; a quarter roam over the whole field range.
    task automatic random_request(input int hot_rows);
        cdu_pkg::op_t                op;
        logic [cdu_pkg::COL_W-1:0]   col;
        logic [cdu_pkg::ROW_W-1:0]   row;
        logic [cdu_pkg::COLOR_W-1:0] color;
        logic [cdu_pkg::CHAR_W-1:0]  ch;
        op  = ($urandom_range(0, 9) < 3) ? cdu_pkg::OP_FLUSH : cdu_pkg::OP_PLOT;
        col = cdu_pkg::COL_W'($urandom_range(0, cdu_pkg::COLS - 1));
        if ($urandom_range(0, 3) == 0)
            row = cdu_pkg::ROW_W'($urandom_range(0, cdu_pkg::ROWS - 1));
        else
            row = cdu_pkg::ROW_W'($urandom_range(0, hot_rows - 1));
        case ($urandom_range(0, 9))
            0, 1:    ch = cdu_pkg::EMPTY_CHAR;
            2:       ch = '0;
            default: ch = cdu_pkg::CHAR_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       color = '0;
            1:       color = '1;
            default: color = cdu_pkg::COLOR_W'($urandom);
        endcase
        send_request(op, col, row, color, ch);
    endtask

    // Holds the register write valid high until the block takes the write.
    task automatic write_reg(input logic [cdu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cdu_pkg::SIZE_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    task automatic set_size(input logic [cdu_pkg::SIZE_W-1:0] cols,
                            input logic [cdu_pkg::SIZE_W-1:0] rows);
        write_reg(cdu_pkg::REG_ACTIVE_COLS, cols);
        write_reg(cdu_pkg::REG_ACTIVE_ROWS, rows);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stops offering requests and waits until every forecast result has been
    // taken, then gives any silent flushes still in the block time to finish.
    // The first edge lets the checker's count catch up with the last request.
    task automatic drain();
        items_ch.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int count, input int hot_rows);
        repeat (count) random_request(hot_rows);
        drain();
    endtask

    // Result side. Each result is preceded by a drawn stall; once, on request
    // from the stimulus, ready is held low for a long stretch so that the
    // block backs up and stops taking requests.
    initial
    begin
        int  stall;
        bit  long_hold_done;
        long_hold_done = 1'b0;
        results_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req && !long_hold_done)
            begin
                results_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1'b1;
            end
            stall = draw_wait(take_left, take_gappy);
            if (stall > 0)
            begin
                results_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results_ch.ready <= 1'b1;
            @(posedge clk);
            while (!results_ch.valid) @(posedge clk);
        end
    end

    // Request side and verdict.
    initial
    begin
        rst_n              = 1'b0;
        long_hold_req      = 1'b0;
        items_ch.valid     = 1'b0;
        items_ch.op        = cdu_pkg::OP_PLOT;
        items_ch.col       = '0;
        items_ch.row       = '0;
        items_ch.color     = '0;
        items_ch.character = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.idx         = cdu_pkg::REG_ACTIVE_COLS;
        cfg_ch.data        = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with the sizes in force after reset (30 by 30).
        // An empty character with a colour still differs from the zero reset cell.
        send_request(cdu_pkg::OP_PLOT, 5'd0, 5'd0, 16'hFFFF, cdu_pkg::EMPTY_CHAR);
        // Plots on or past the active edge, or past the last row, are dropped.
        send_request(cdu_pkg::OP_PLOT, 5'd30, 5'd0, 16'h1234, 8'h41);
        send_request(cdu_pkg::OP_PLOT, 5'd31, 5'd31, 16'hFFFF, 8'h00);
        send_request(cdu_pkg::OP_PLOT, 5'd5, 5'd30, 16'h00FF, 8'hC3);
        send_request(cdu_pkg::OP_PLOT, 5'd29, 5'd29, 16'hA5A5, 8'h5A);
        // Content equal to the shown cell reports nothing.
        send_request(cdu_pkg::OP_PLOT, 5'd29, 5'd0, 16'h0000, 8'h00);
        // The column of a flush is ignored; first flush reports column 0 only.
        send_request(cdu_pkg::OP_FLUSH, 5'd31, 5'd0, 16'hFFFF, 8'hFF);
        // The flush left every pending cell empty, so the rest of the row erases.
        send_request(cdu_pkg::OP_FLUSH, 5'd0, 5'd0, 16'h0000, 8'h00);
        // Nothing has changed in row 0 since: no results.
        send_request(cdu_pkg::OP_FLUSH, 5'd17, 5'd0, 16'h5555, 8'hAA);
        // The plot in row 29 is reported on its own.
        send_request(cdu_pkg::OP_FLUSH, 5'd0, 5'd29, 16'h0000, 8'h00);
        // A second plot of the same cell overwrites the first.
        send_request(cdu_pkg::OP_PLOT, 5'd3, 5'd1, 16'h0F0F, 8'h41);
        send_request(cdu_pkg::OP_PLOT, 5'd3, 5'd1, 16'hF0F0, 8'h42);
        send_request(cdu_pkg::OP_PLOT, 5'd0, 5'd1, 16'h0000, 8'h00);
        send_request(cdu_pkg::OP_FLUSH, 5'd0, 5'd1, 16'h0000, 8'h00);
        // Two empty cells that differ only in colour still count as a change.
        send_request(cdu_pkg::OP_PLOT, 5'd0, 5'd0, 16'h0001, cdu_pkg::EMPTY_CHAR);
        send_request(cdu_pkg::OP_FLUSH, 5'd0, 5'd0, 16'h0000, 8'h00);
        send_request(cdu_pkg::OP_PLOT, 5'd28, 5'd28, 16'h8000, 8'h7F);
        send_request(cdu_pkg::OP_PLOT, 5'd1, 5'd28, 16'h7FFF, 8'h80);
        send_request(cdu_pkg::OP_FLUSH, 5'd0, 5'd28, 16'h0000, 8'h00);
        // A row never plotted still holds the reset cells: no results.
        send_request(cdu_pkg::OP_FLUSH, 5'd0, 5'd31, 16'h0000, 8'h00);
        // Every pending cell of row 29 is now empty: the whole row erases.
        send_request(cdu_pkg::OP_FLUSH, 5'd0, 5'd29, 16'h0000, 8'h00);
        drain();

        // Random traffic at the reset size, with the one long result stall.
        long_hold_req <= 1'b1;
        random_phase(100, 4);

        // Smallest area: a single cell.
        set_size(6'd1, 6'd1);
        random_phase(60, 1);

        // The full physical area.
        set_size(6'd32, 6'd32);
        random_phase(90, 4);

        // A write to an undecoded index, then a zero area that drops every
        // plot; flushes still erase what earlier phases left behind.
        write_reg(REG_UNUSED, cdu_pkg::SIZE_W'($urandom));
        set_size(6'd0, 6'd0);
        random_phase(30, 4);

        // Oversized registers are bounded by the physical area.
        set_size(6'd63, 6'd63);
        random_phase(80, 4);

        // A random area within the physical bounds.
        set_size(cdu_pkg::SIZE_W'($urandom_range(1, cdu_pkg::COLS)),
                 cdu_pkg::SIZE_W'($urandom_range(1, cdu_pkg::ROWS)));
        random_phase(80, 4);

        if (errors == 0)
            $display("tb_char_cell_dirty_update: clean");
        else
            $display("tb_char_cell_dirty_update: errors");
        $finish;
    end

    // Guard against a hang anywhere in the run.
    initial
    begin
        #(LIMIT_NS);
        $display("%0t ns: timeout with %0d results still expected", $time, waiting);
        $display("tb_char_cell_dirty_update: errors");
        $finish;
    end

endmodule

>>> sim.f
design/cdu_pkg.sv
design/cdu_if.sv
design/cdu_front.sv
design/cdu_queue.sv
design/cdu_back.sv
design/char_cell_dirty_update.sv
test/cdu_checker.sv
test/tb_char_cell_dirty_update.sv
